// ----- rtl/xor_checked_packet_deframer_macros.svh -----
`ifndef XOR_CHECKED_PACKET_DEFRAMER_MACROS_SVH
`define XOR_CHECKED_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define XCPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define XCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/xcpd_pkg.sv -----
`default_nettype none

package xcpd_pkg;

  localparam logic [7:0] HdrFirst  = 8'h02;
  localparam logic [7:0] HdrSecond = 8'hB5;
  localparam logic [7:0] CodeSetCfg = 8'd101;
  localparam logic [7:0] CodeReqLo  = 8'd1;
  localparam logic [7:0] CodeReqHi  = 8'd4;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgImageSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVersion   = 1'b1;

  localparam logic [15:0] ImageSizeReset = 16'd128;
  localparam logic [15:0] VersionReset   = 16'd1;

  typedef enum logic [2:0] {
    EvNone      = 3'd0,
    EvPayload   = 3'd1,
    EvReqOk     = 3'd2,
    EvBadCheck  = 3'd3,
    EvSetCfgOk  = 3'd4,
    EvSetCfgRej = 3'd5,
    EvUnknown   = 3'd6
  } event_kind_e;

  typedef enum logic [6:0] {
    PhHunt    = 7'b0000001,
    PhHdr2    = 7'b0000010,
    PhCode    = 7'b0000100,
    PhLenLo   = 7'b0001000,
    PhLenHi   = 7'b0010000,
    PhPayload = 7'b0100000,
    PhCheck   = 7'b1000000
  } phase_e;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  code;
    logic [7:0]  pbyte;
    logic [15:0] pindex;
    logic [15:0] rlen;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/xor_checked_packet_deframer.sv -----
// channel | handshake                   | payload
// --------+-----------------------------+----------------------------------------------
// input   | in_valid_i / in_stall_o     | rx_byte_i
// output  | out_valid_o / out_stall_i   | event_kind_o frame_code_o payload_byte_o
//         |                             | payload_index_o received_length_o
// config  | cfg_we_i                    | cfg_idx_i cfg_data_i
//
// One beat in, one beat out; a beat may enter every cycle while in_stall_o is low.
// The frame state updates as the beat is taken, and the result is registered in a
// two-entry output stage (result register plus skid).
// in_stall_o rises only when both entries are full, i.e. after out_stall_i holds a beat.
// Reset clears the frame state to the header hunt and the registers to 128 and 1.
`default_nettype none

module xor_checked_packet_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         event_kind_o,
  output logic [7:0]                         frame_code_o,
  output logic [7:0]                         payload_byte_o,
  output logic [15:0]                        payload_index_o,
  output logic [15:0]                        received_length_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [xcpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [xcpd_pkg::CfgDataW-1:0] cfg_data_i
);

  xcpd_pkg::result_t step_res;
  xcpd_pkg::result_t out_res;
  logic              step;

  assign step = in_valid_i && !in_stall_o;

  xcpd_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (step_res)
  );

  xcpd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (step_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign event_kind_o      = out_res.kind;
  assign frame_code_o      = out_res.code;
  assign payload_byte_o    = out_res.pbyte;
  assign payload_index_o   = out_res.pindex;
  assign received_length_o = out_res.rlen;

endmodule

`default_nettype wire

// ----- rtl/xcpd_parse.sv -----
`default_nettype none

module xcpd_parse (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [xcpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [xcpd_pkg::CfgDataW-1:0] cfg_data_i,
  output xcpd_pkg::result_t                 result_o
);

  xcpd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  check_q, check_d;
  logic [15:0] exp_len_q, exp_len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] first2_q, first2_d;
  logic [15:0] image_size_q;
  logic [15:0] version_q;
  logic [15:0] count_inc;
  xcpd_pkg::event_kind_e verdict;

  assign count_inc = count_q + 16'd1;

  always_comb begin
    if (rx_byte_i != check_q) begin
      verdict = xcpd_pkg::EvBadCheck;
    end else if (code_q >= xcpd_pkg::CodeReqLo && code_q <= xcpd_pkg::CodeReqHi) begin
      verdict = xcpd_pkg::EvReqOk;
    end else if (code_q == xcpd_pkg::CodeSetCfg) begin
      verdict = (count_q == image_size_q && first2_q == version_q) ?
                xcpd_pkg::EvSetCfgOk : xcpd_pkg::EvSetCfgRej;
    end else begin
      verdict = xcpd_pkg::EvUnknown;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    code_d    = code_q;
    check_d   = check_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    first2_d  = first2_q;
    result_o.kind   = xcpd_pkg::EvNone;
    result_o.pbyte  = 8'd0;
    result_o.pindex = 16'd0;
    result_o.rlen   = 16'd0;
    unique case (phase_q)
      xcpd_pkg::PhHdr2: begin
        phase_d = (rx_byte_i == xcpd_pkg::HdrSecond) ? xcpd_pkg::PhCode : xcpd_pkg::PhHunt;
      end
      xcpd_pkg::PhCode: begin
        code_d  = rx_byte_i;
        check_d = rx_byte_i;
        phase_d = xcpd_pkg::PhLenLo;
      end
      xcpd_pkg::PhLenLo: begin
        exp_len_d = {8'd0, rx_byte_i};
        check_d   = check_q ^ rx_byte_i;
        phase_d   = xcpd_pkg::PhLenHi;
      end
      xcpd_pkg::PhLenHi: begin
        exp_len_d = {rx_byte_i, exp_len_q[7:0]};
        check_d   = check_q ^ rx_byte_i;
        phase_d   = xcpd_pkg::PhPayload;
      end
      xcpd_pkg::PhPayload: begin
        result_o.kind   = xcpd_pkg::EvPayload;
        result_o.pbyte  = rx_byte_i;
        result_o.pindex = count_q;
        if (count_q == 16'd0) begin
          first2_d = {first2_q[15:8], rx_byte_i};
        end else if (count_q == 16'd1) begin
          first2_d = {rx_byte_i, first2_q[7:0]};
        end
        check_d = check_q ^ rx_byte_i;
        count_d = count_inc;
        if (count_inc >= exp_len_q) begin
          phase_d = xcpd_pkg::PhCheck;
        end
      end
      xcpd_pkg::PhCheck: begin
        result_o.kind = verdict;
        result_o.rlen = count_q;
        count_d  = 16'd0;
        first2_d = 16'd0;
        phase_d  = xcpd_pkg::PhHunt;
      end
      default: begin
        phase_d = (rx_byte_i == xcpd_pkg::HdrFirst) ? xcpd_pkg::PhHdr2 : xcpd_pkg::PhHunt;
      end
    endcase
    result_o.code = code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= xcpd_pkg::PhHunt;
      code_q    <= 8'd0;
      check_q   <= 8'd0;
      exp_len_q <= 16'd0;
      count_q   <= 16'd0;
      first2_q  <= 16'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      code_q    <= code_d;
      check_q   <= check_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
      first2_q  <= first2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= xcpd_pkg::ImageSizeReset;
      version_q    <= xcpd_pkg::VersionReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xcpd_pkg::CfgImageSize: image_size_q <= cfg_data_i;
        xcpd_pkg::CfgVersion:   version_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xcpd_skid.sv -----
`default_nettype none

module xcpd_skid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire xcpd_pkg::result_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output xcpd_pkg::result_t       out_data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  xcpd_pkg::result_t out_q;
  xcpd_pkg::result_t skid_q;
  logic              accept;
  logic              pop;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign pop         = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !pop) begin
        skid_q <= in_data_i;
      end else begin
        out_q <= in_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xcpd_checker.sv -----
`default_nettype none

`include "xor_checked_packet_deframer_macros.svh"

module xcpd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  event_kind_o,
  input wire logic [7:0]  frame_code_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic [15:0] payload_index_o,
  input wire logic [15:0] received_length_o
);

  `XCPD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(event_kind_o) && $stable(frame_code_o) && $stable(payload_byte_o) && $stable(payload_index_o) && $stable(received_length_o), "stalled output beat changed")
  `XCPD_ASSERT_NOW(a_stall_needs_out, in_stall_o, out_valid_o, "input stalled with no output beat held")
  `XCPD_ASSERT_NOW(a_stall_cause, $rose(in_stall_o), $past(out_valid_o && out_stall_i), "input stall rose without output stall")
  `XCPD_ASSERT_NOW(a_payload_zero, out_valid_o && event_kind_o != xcpd_pkg::EvPayload, payload_byte_o == 8'd0 && payload_index_o == 16'd0, "payload fields set outside payload beat")
  `XCPD_ASSERT_NOW(a_rlen_zero, out_valid_o && (event_kind_o == xcpd_pkg::EvNone || event_kind_o == xcpd_pkg::EvPayload), received_length_o == 16'd0, "length set outside verdict beat")

endmodule

bind xor_checked_packet_deframer xcpd_checker u_xcpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .event_kind_o      (event_kind_o),
  .frame_code_o      (frame_code_o),
  .payload_byte_o    (payload_byte_o),
  .payload_index_o   (payload_index_o),
  .received_length_o (received_length_o)
);

`default_nettype wire

// ----- tb/xor_checked_packet_deframer_tb.sv -----
`timescale 1ns / 100ps

module xor_checked_packet_deframer_tb;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned NumPlans = 10;
  localparam int unsigned BeatsPerPlan = 75;

  typedef struct packed {
    logic [7:0]        rx;
    logic              typed;
    xcpd_pkg::result_t want;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    rx_byte_i = 8'h00;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [2:0]                    event_kind_o;
  logic [7:0]                    frame_code_o;
  logic [7:0]                    payload_byte_o;
  logic [15:0]                   payload_index_o;
  logic [15:0]                   received_length_o;
  logic                          cfg_we_i = 1'b0;
  logic [xcpd_pkg::CfgIdxW-1:0]  cfg_idx_i = xcpd_pkg::CfgImageSize;
  logic [xcpd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // deframer state as predicted
  xcpd_pkg::phase_e frame_phase = xcpd_pkg::PhHunt;
  logic [7:0]  held_code = 8'h00;
  logic [7:0]  xor_sum = 8'h00;
  logic [15:0] length_field = 16'd0;
  logic [15:0] bytes_taken = 16'd0;
  logic [15:0] version_seen = 16'd0;
  logic [15:0] image_size = xcpd_pkg::ImageSizeReset;
  logic [15:0] version = xcpd_pkg::VersionReset;

  xcpd_pkg::result_t events_due [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned cycles_run = 0;
  int unsigned stall_left = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  logic [15:0] size_plan [NumPlans] = '{16'd128, 16'd2, 16'd2, 16'd1, 16'd1,
                                        16'd0, 16'd65535, 16'd0, 16'd3, 16'd6};
  logic [15:0] version_plan [NumPlans] = '{16'h0001, 16'h0000, 16'hFFFF, 16'h00A5,
                                           16'h12A5, 16'h1234, 16'hFFFF, 16'h0000,
                                           16'h5AA5, 16'h0000};

  stim_row_t directed_rows [24] = '{
    '{8'h02, 1'b1, '{xcpd_pkg::EvNone, 8'h00, 8'h00, 16'd0, 16'd0}},
    '{8'h02, 1'b1, '{xcpd_pkg::EvNone, 8'h00, 8'h00, 16'd0, 16'd0}},
    '{8'hB5, 1'b1, '{xcpd_pkg::EvNone, 8'h00, 8'h00, 16'd0, 16'd0}},
    '{8'h02, 1'b0, '0},
    '{8'hB5, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'hAB, 1'b1, '{xcpd_pkg::EvReqOk, 8'h01, 8'h00, 16'd0, 16'd1}},
    '{8'h02, 1'b0, '0},
    '{8'hB5, 1'b0, '0},
    '{8'h65, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{xcpd_pkg::EvBadCheck, 8'h65, 8'h00, 16'd0, 16'd1}},
    '{8'h02, 1'b0, '0},
    '{8'hB5, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b1, '{xcpd_pkg::EvUnknown, 8'hFF, 8'h00, 16'd0, 16'd1}}
  };

  xor_checked_packet_deframer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_kind_o      (event_kind_o),
    .frame_code_o      (frame_code_o),
    .payload_byte_o    (payload_byte_o),
    .payload_index_o   (payload_index_o),
    .received_length_o (received_length_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic xcpd_pkg::result_t deframe_byte(input logic [7:0] b);
    xcpd_pkg::result_t r;
    r = '0;
    case (frame_phase)
      xcpd_pkg::PhHdr2: begin
        frame_phase = (b == xcpd_pkg::HdrSecond) ? xcpd_pkg::PhCode : xcpd_pkg::PhHunt;
      end
      xcpd_pkg::PhCode: begin
        held_code   = b;
        xor_sum     = b;
        frame_phase = xcpd_pkg::PhLenLo;
      end
      xcpd_pkg::PhLenLo: begin
        length_field = {8'h00, b};
        xor_sum      = xor_sum ^ b;
        frame_phase  = xcpd_pkg::PhLenHi;
      end
      xcpd_pkg::PhLenHi: begin
        length_field[15:8] = b;
        xor_sum            = xor_sum ^ b;
        frame_phase        = xcpd_pkg::PhPayload;
      end
      xcpd_pkg::PhPayload: begin
        r.kind   = xcpd_pkg::EvPayload;
        r.pbyte  = b;
        r.pindex = bytes_taken;
        if (bytes_taken == 16'd0) version_seen[7:0] = b;
        else if (bytes_taken == 16'd1) version_seen[15:8] = b;
        xor_sum     = xor_sum ^ b;
        bytes_taken = bytes_taken + 16'd1;
        if (bytes_taken >= length_field) frame_phase = xcpd_pkg::PhCheck;
      end
      xcpd_pkg::PhCheck: begin
        if (b != xor_sum) r.kind = xcpd_pkg::EvBadCheck;
        else if (held_code >= xcpd_pkg::CodeReqLo && held_code <= xcpd_pkg::CodeReqHi)
          r.kind = xcpd_pkg::EvReqOk;
        else if (held_code == xcpd_pkg::CodeSetCfg)
          r.kind = (bytes_taken == image_size && version_seen == version) ?
                   xcpd_pkg::EvSetCfgOk : xcpd_pkg::EvSetCfgRej;
        else r.kind = xcpd_pkg::EvUnknown;
        r.rlen       = bytes_taken;
        bytes_taken  = 16'd0;
        version_seen = 16'd0;
        frame_phase  = xcpd_pkg::PhHunt;
      end
      default: begin
        frame_phase = (b == xcpd_pkg::HdrFirst) ? xcpd_pkg::PhHdr2 : xcpd_pkg::PhHunt;
      end
    endcase
    r.code = held_code;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_event();
    xcpd_pkg::result_t want;
    if (events_due.size() == 0) begin
      $error("event_kind: expected no beat, actual %0d", event_kind_o);
      mismatches++;
    end else begin
      want = events_due.pop_front();
      compare_field("event_kind", 16'(want.kind), 16'(event_kind_o));
      compare_field("frame_code", 16'(want.code), 16'(frame_code_o));
      compare_field("payload_byte", 16'(want.pbyte), 16'(payload_byte_o));
      compare_field("payload_index", want.pindex, payload_index_o);
      compare_field("received_length", want.rlen, received_length_o);
    end
  endtask

  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      check_event();
    end
  end

  // hold results back in bursts
  always @(posedge clk_i) begin
    if (!sink_stalls_on) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 19);
      out_stall_i <= 1'b1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic typed,
                           input xcpd_pkg::result_t want);
    xcpd_pkg::result_t predicted;
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    predicted = deframe_byte(b);
    events_due.push_back(typed ? want : predicted);
    beats_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] size, input logic [15:0] ver);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= xcpd_pkg::CfgImageSize;
    cfg_data_i <= size;
    @(posedge clk_i);
    image_size = size;
    cfg_idx_i  <= xcpd_pkg::CfgVersion;
    cfg_data_i <= ver;
    @(posedge clk_i);
    version = ver;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame();
    logic [7:0]  code;
    logic [7:0]  chk;
    logic [7:0]  nb;
    logic [15:0] len;
    logic [7:0]  body [$];
    int unsigned pick;
    int unsigned n;
    // line noise and broken headers
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        nb = 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
          if (nb == xcpd_pkg::HdrSecond) nb = ~nb;
          send_beat(xcpd_pkg::HdrFirst, 1'b0, '0);
          send_beat(nb, 1'b0, '0);
        end else begin
          if (nb == xcpd_pkg::HdrFirst) nb = ~nb;
          send_beat(nb, 1'b0, '0);
        end
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) code = 8'($urandom_range(xcpd_pkg::CodeReqLo, xcpd_pkg::CodeReqHi));
    else if (pick < 7) code = xcpd_pkg::CodeSetCfg;
    else code = 8'($urandom_range(0, 255));
    if (code == xcpd_pkg::CodeSetCfg && $urandom_range(0, 3) != 0 &&
        image_size <= 16'd200) begin
      len = image_size;
    end else begin
      pick = $urandom_range(0, 49);
      if (pick == 0) len = 16'($urandom_range(256, 300));
      else if (pick < 4) len = 16'($urandom_range(9, 200));
      else len = 16'($urandom_range(0, 8));
    end
    n = (len == 16'd0) ? 1 : len;
    for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    if (code == xcpd_pkg::CodeSetCfg && $urandom_range(0, 3) != 0) begin
      body[0] = version[7:0];
      if (n > 1) body[1] = version[15:8];
    end
    chk = code ^ len[7:0] ^ len[15:8];
    foreach (body[k]) chk = chk ^ body[k];
    if ($urandom_range(0, 7) == 0) chk = chk ^ 8'($urandom_range(1, 255));
    send_beat(xcpd_pkg::HdrFirst, 1'b0, '0);
    send_beat(xcpd_pkg::HdrSecond, 1'b0, '0);
    send_beat(code, 1'b0, '0);
    send_beat(len[7:0], 1'b0, '0);
    send_beat(len[15:8], 1'b0, '0);
    foreach (body[k]) send_beat(body[k], 1'b0, '0);
    send_beat(chk, 1'b0, '0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[r])
      send_beat(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].want);
    size_plan[7]    = 16'($urandom_range(2, 24));
    version_plan[7] = 16'($urandom);
    version_plan[9] = 16'($urandom);
    for (int p = 0; p < NumPlans; p++) begin
      if (p > 0) begin
        drain();
        configure(size_plan[p], version_plan[p]);
      end
      // no idling mid-run and in the closing stretch
      src_gaps_on    = (p != 2 && p != NumPlans - 1);
      sink_stalls_on = (p != 2 && p != NumPlans - 1);
      while (beats_sent < 24 + (p + 1) * BeatsPerPlan) send_frame();
    end
    drain();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
